### hdl/i2cem_pkg.sv
`default_nettype none

package i2cem_pkg;

    // Default geometry of the attached memory
    localparam int DEF_PAGE_BYTES   = 8;
    localparam int DEF_MEMORY_BYTES = 256;

    // Configuration register indexes
    localparam logic CFG_DEVICE_ADDRESS   = 1'b0;
    localparam logic CFG_WRITE_WAIT_TICKS = 1'b1;

    // Configuration reset values
    localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'h50;
    localparam logic [15:0] WRITE_WAIT_RST     = 16'd5000;

    // Command codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Completion status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_DEV_NACK    = 3'd1;
    localparam logic [2:0] ST_WORD_NACK   = 3'd2;
    localparam logic [2:0] ST_DATA_NACK   = 3'd3;
    localparam logic [2:0] ST_READ_NACK   = 3'd4;

    // One tick beat in
    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] start_address;
        logic [8:0] byte_count;
        logic [7:0] write_byte;
        logic       sda_in;
    } cmd_t;

    // One tick beat out
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       data_request;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       done_res;
        logic [2:0] status;
    } res_t;

endpackage

`default_nettype wire

### hdl/i2cem_engine.sv
`default_nettype none

module i2cem_engine #(
    parameter int PAGE_BYTES   = i2cem_pkg::DEF_PAGE_BYTES,
    parameter int MEMORY_BYTES = i2cem_pkg::DEF_MEMORY_BYTES
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step_en,
    input  wire i2cem_pkg::cmd_t  cmd,
    input  wire logic [6:0]       device_address,
    input  wire logic [15:0]      write_wait_ticks,
    output i2cem_pkg::res_t       res
);
    import i2cem_pkg::*;

    localparam int PAGE_W = $clog2(PAGE_BYTES + 1);

    typedef logic [PAGE_W-1:0] page_cnt_t;

    typedef enum logic [4:0] {
        PH_IDLE        = 5'd0,
        PH_START_HI    = 5'd1,
        PH_START_LO    = 5'd2,
        PH_DEVW_BITS   = 5'd3,
        PH_DEVW_ACK_LO = 5'd4,
        PH_DEVW_ACK_HI = 5'd5,
        PH_WORD_BITS   = 5'd6,
        PH_WORD_ACK_LO = 5'd7,
        PH_WORD_ACK_HI = 5'd8,
        PH_DATA_BITS   = 5'd9,
        PH_DATA_ACK_LO = 5'd10,
        PH_DATA_ACK_HI = 5'd11,
        PH_RS_PREP     = 5'd12,
        PH_RS_HI       = 5'd13,
        PH_RS_LO       = 5'd14,
        PH_DEVR_BITS   = 5'd15,
        PH_DEVR_ACK_LO = 5'd16,
        PH_DEVR_ACK_HI = 5'd17,
        PH_RECV_BITS   = 5'd18,
        PH_MACK_LO     = 5'd19,
        PH_MACK_HI     = 5'd20,
        PH_STOP_PREP   = 5'd21,
        PH_STOP_HI     = 5'd22,
        PH_STOP_REL    = 5'd23,
        PH_WAIT        = 5'd24
    } phase_t;

    // Address modulo memory size, built at elaboration
    function automatic logic [255:0][7:0] addr_mod_fn();
        logic [255:0][7:0] t;
        logic [8:0]        r;
        begin
            r = 9'd0;
            for (int i = 0; i < 256; i++)
            begin
                t[i] = r[7:0];
                r = ((r + 9'd1) == 9'(MEMORY_BYTES)) ? 9'd0 : r + 9'd1;
            end
            return t;
        end
    endfunction

    // Room left in the page from each address, built at elaboration
    function automatic logic [255:0][PAGE_W-1:0] page_room_fn();
        logic [255:0][PAGE_W-1:0] t;
        page_cnt_t                r;
        begin
            r = '0;
            for (int i = 0; i < 256; i++)
            begin
                t[i] = page_cnt_t'(PAGE_BYTES) - r;
                r = ((r + page_cnt_t'(1)) == page_cnt_t'(PAGE_BYTES)) ? '0
                                                                      : r + page_cnt_t'(1);
            end
            return t;
        end
    endfunction

    localparam logic [255:0][7:0]        ADDR_MOD  = addr_mod_fn();
    localparam logic [255:0][PAGE_W-1:0] PAGE_ROOM = page_room_fn();

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  addr_reg, addr_next;
    logic [8:0]  bytes_left_reg, bytes_left_next;
    page_cnt_t   page_left_reg, page_left_next;
    logic [15:0] wait_reg, wait_next;
    logic        read_mode_reg, read_mode_next;
    logic [2:0]  status_reg, status_next;

    logic        scl, sdo, req, rv, done, next_page;
    logic [7:0]  tx_byte;
    logic [8:0]  cnt_clamp;
    logic [7:0]  addr_inc;
    logic [8:0]  bytes_dec;
    page_cnt_t   page_dec;
    page_cnt_t   room;
    logic [7:0]  cmd_addr;
    page_cnt_t   cmd_room;
    logic [15:0] wait_dec;

    // Shared small arithmetic
    always_comb
    begin
        cnt_clamp = (cmd.byte_count > 9'(MEMORY_BYTES)) ? 9'(MEMORY_BYTES) : cmd.byte_count;
        cmd_addr  = ADDR_MOD[cmd.start_address];
        cmd_room  = PAGE_ROOM[cmd_addr];
        room      = PAGE_ROOM[addr_reg];
        addr_inc  = ((9'(addr_reg) + 9'd1) == 9'(MEMORY_BYTES)) ? 8'd0 : addr_reg + 8'd1;
        bytes_dec = (bytes_left_reg != 9'd0) ? bytes_left_reg - 9'd1 : 9'd0;
        page_dec  = (page_left_reg != '0) ? page_left_reg - page_cnt_t'(1) : '0;
        wait_dec  = (wait_reg != 16'd0) ? wait_reg - 16'd1 : 16'd0;
        tx_byte   = (phase_reg == PH_DATA_BITS && bit_index_reg == 4'd0) ? cmd.write_byte
                                                                         : shift_reg;
    end

    // One bus tick
    always_comb
    begin
        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        addr_next       = addr_reg;
        bytes_left_next = bytes_left_reg;
        page_left_next  = page_left_reg;
        wait_next       = wait_reg;
        read_mode_next  = read_mode_reg;
        status_next     = status_reg;
        scl       = 1'b1;
        sdo       = 1'b1;
        req       = 1'b0;
        rv        = 1'b0;
        done      = 1'b0;
        next_page = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (cmd.operation == OP_WRITE || cmd.operation == OP_READ)
                begin
                    status_next    = ST_OK;
                    read_mode_next = (cmd.operation == OP_READ);
                    addr_next      = cmd_addr;
                    if (cnt_clamp == 9'd0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        bytes_left_next = cnt_clamp;
                        if (cmd.operation == OP_READ)
                            page_left_next = '0;
                        else
                            page_left_next = (9'(cmd_room) < cnt_clamp) ? cmd_room
                                                                        : cnt_clamp[PAGE_W-1:0];
                        phase_next = PH_START_LO;
                    end
                end
            end
            PH_START_HI:
            begin
                phase_next = PH_START_LO;
            end
            PH_START_LO:
            begin
                sdo            = 1'b0;
                shift_next     = {device_address, 1'b0};
                bit_index_next = 4'd0;
                phase_next     = PH_DEVW_BITS;
            end
            PH_DEVW_BITS, PH_WORD_BITS, PH_DATA_BITS, PH_DEVR_BITS:
            begin
                shift_next = tx_byte;
                scl        = bit_index_reg[0];
                sdo        = tx_byte[3'd7 - bit_index_reg[3:1]];
                if (bit_index_reg == 4'd15)
                begin
                    bit_index_next = 4'd0;
                    case (phase_reg)
                        PH_DEVW_BITS: phase_next = PH_DEVW_ACK_LO;
                        PH_WORD_BITS: phase_next = PH_WORD_ACK_LO;
                        PH_DATA_BITS: phase_next = PH_DATA_ACK_LO;
                        default:      phase_next = PH_DEVR_ACK_LO;
                    endcase
                end
                else
                begin
                    bit_index_next = bit_index_reg + 4'd1;
                end
            end
            PH_DEVW_ACK_LO:
            begin
                scl        = 1'b0;
                phase_next = PH_DEVW_ACK_HI;
            end
            PH_WORD_ACK_LO:
            begin
                scl        = 1'b0;
                phase_next = PH_WORD_ACK_HI;
            end
            PH_DATA_ACK_LO:
            begin
                scl        = 1'b0;
                phase_next = PH_DATA_ACK_HI;
            end
            PH_DEVR_ACK_LO:
            begin
                scl        = 1'b0;
                phase_next = PH_DEVR_ACK_HI;
            end
            PH_DEVW_ACK_HI:
            begin
                if (cmd.sda_in)
                begin
                    status_next = ST_DEV_NACK;
                    phase_next  = PH_STOP_PREP;
                end
                else
                begin
                    shift_next     = addr_reg;
                    bit_index_next = 4'd0;
                    phase_next     = PH_WORD_BITS;
                end
            end
            PH_WORD_ACK_HI:
            begin
                if (cmd.sda_in)
                begin
                    status_next = ST_WORD_NACK;
                    phase_next  = PH_STOP_PREP;
                end
                else if (read_mode_reg)
                begin
                    phase_next = PH_RS_PREP;
                end
                else
                begin
                    req            = 1'b1;
                    bit_index_next = 4'd0;
                    phase_next     = PH_DATA_BITS;
                end
            end
            PH_DATA_ACK_HI:
            begin
                if (cmd.sda_in)
                begin
                    status_next = ST_DATA_NACK;
                    phase_next  = PH_STOP_PREP;
                end
                else
                begin
                    addr_next       = addr_inc;
                    bytes_left_next = bytes_dec;
                    page_left_next  = page_dec;
                    if (page_dec != '0 && bytes_dec != 9'd0)
                    begin
                        req            = 1'b1;
                        bit_index_next = 4'd0;
                        phase_next     = PH_DATA_BITS;
                    end
                    else
                    begin
                        phase_next = PH_STOP_PREP;
                    end
                end
            end
            PH_RS_PREP:
            begin
                scl        = 1'b0;
                phase_next = PH_RS_HI;
            end
            PH_RS_HI:
            begin
                phase_next = PH_RS_LO;
            end
            PH_RS_LO:
            begin
                sdo            = 1'b0;
                shift_next     = {device_address, 1'b1};
                bit_index_next = 4'd0;
                phase_next     = PH_DEVR_BITS;
            end
            PH_DEVR_ACK_HI:
            begin
                if (cmd.sda_in)
                begin
                    status_next = ST_READ_NACK;
                    phase_next  = PH_STOP_PREP;
                end
                else
                begin
                    shift_next     = 8'd0;
                    bit_index_next = 4'd0;
                    phase_next     = PH_RECV_BITS;
                end
            end
            PH_RECV_BITS:
            begin
                scl = bit_index_reg[0];
                // sample on the SCL-high half of each bit
                if (bit_index_reg[0])
                    shift_next = {shift_reg[6:0], cmd.sda_in};
                if (bit_index_reg == 4'd15)
                begin
                    rv             = 1'b1;
                    bit_index_next = 4'd0;
                    phase_next     = PH_MACK_LO;
                end
                else
                begin
                    bit_index_next = bit_index_reg + 4'd1;
                end
            end
            PH_MACK_LO:
            begin
                scl        = 1'b0;
                sdo        = (bytes_left_reg <= 9'd1);
                phase_next = PH_MACK_HI;
            end
            PH_MACK_HI:
            begin
                sdo             = (bytes_left_reg <= 9'd1);
                addr_next       = addr_inc;
                bytes_left_next = bytes_dec;
                if (bytes_dec == 9'd0)
                begin
                    phase_next = PH_STOP_PREP;
                end
                else
                begin
                    shift_next     = 8'd0;
                    bit_index_next = 4'd0;
                    phase_next     = PH_RECV_BITS;
                end
            end
            PH_STOP_PREP:
            begin
                scl        = 1'b0;
                sdo        = 1'b0;
                phase_next = PH_STOP_HI;
            end
            PH_STOP_HI:
            begin
                sdo        = 1'b0;
                phase_next = PH_STOP_REL;
            end
            PH_STOP_REL:
            begin
                if (read_mode_reg || status_reg != ST_OK)
                begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
                else if (write_wait_ticks == 16'd0)
                begin
                    next_page = 1'b1;
                end
                else
                begin
                    wait_next  = write_wait_ticks;
                    phase_next = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                wait_next = wait_dec;
                if (wait_dec == 16'd0)
                    next_page = 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // Next page write, or finish after the last one
        if (next_page)
        begin
            if (bytes_left_reg == 9'd0)
            begin
                done       = 1'b1;
                phase_next = PH_IDLE;
            end
            else
            begin
                page_left_next = (9'(room) < bytes_left_reg) ? room
                                                             : bytes_left_reg[PAGE_W-1:0];
                phase_next     = PH_START_HI;
            end
        end
    end

    // Result of this tick
    always_comb
    begin
        res.scl_level    = scl;
        res.sda_level    = sdo;
        res.busy_res     = (phase_next != PH_IDLE);
        res.data_request = req;
        res.read_byte    = rv ? shift_next : 8'd0;
        res.read_valid   = rv;
        res.done_res     = done;
        res.status       = done ? status_next : ST_OK;
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_index_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            addr_reg       <= 8'd0;
            bytes_left_reg <= 9'd0;
            page_left_reg  <= '0;
            wait_reg       <= 16'd0;
            read_mode_reg  <= 1'b0;
            status_reg     <= ST_OK;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            bit_index_reg  <= bit_index_next;
            shift_reg      <= shift_next;
            addr_reg       <= addr_next;
            bytes_left_reg <= bytes_left_next;
            page_left_reg  <= page_left_next;
            wait_reg       <= wait_next;
            read_mode_reg  <= read_mode_next;
            status_reg     <= status_next;
        end
    end

endmodule

`default_nettype wire

### hdl/i2c_eeprom_transaction_master_core.sv
// I2C master for a 24C02-style serial EEPROM. Every beat on cmd is one bus
// phase tick from a prescaler and yields exactly one beat on res with the
// SCL/SDA drive levels for that tick; a command in a tick starts a page-split
// write or a sequential read, and done_res/status close the transfer. One
// tick is taken per clock cycle while no result is held under res_stall:
// a tick is held in the input register, and the sequencer step runs between
// that register and the result register, which presents the result. While a
// result waits under res_stall, one more tick enters the input register and
// cmd then stalls until the result is taken. Configuration writes on the cfg
// channel are always ready and should only be made while the block is idle.
`default_nettype none

module i2c_eeprom_transaction_master_core #(
    parameter int PAGE_BYTES   = i2cem_pkg::DEF_PAGE_BYTES,
    parameter int MEMORY_BYTES = i2cem_pkg::DEF_MEMORY_BYTES
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_stall,
    input  wire i2cem_pkg::cmd_t  cmd_data,
    output logic                  res_valid,
    input  wire logic             res_stall,
    output i2cem_pkg::res_t       res_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_index,
    input  wire logic [15:0]      cfg_data
);
    import i2cem_pkg::*;

    logic        cmd_full_reg, cmd_full_next;
    cmd_t        cmd_buf_reg;
    logic        res_valid_reg, res_valid_next;
    res_t        res_buf_reg;
    logic [6:0]  dev_addr_reg;
    logic [15:0] wait_ticks_reg;
    logic        advance;
    logic        cmd_take;
    res_t        step_res;

    // Handshake between input register and result register
    assign advance        = cmd_full_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall      = cmd_full_reg && !advance;
    assign cmd_take       = cmd_valid && !cmd_stall;
    assign cmd_full_next  = cmd_take || (cmd_full_reg && !advance);
    assign res_valid_next = advance || (res_valid_reg && res_stall);
    assign res_valid      = res_valid_reg;
    assign res_data       = res_buf_reg;
    assign cfg_ready      = 1'b1;

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_full_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_full_reg  <= cmd_full_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_take)
            cmd_buf_reg <= cmd_data;
        if (advance)
            res_buf_reg <= step_res;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg   <= DEVICE_ADDRESS_RST;
            wait_ticks_reg <= WRITE_WAIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS:   dev_addr_reg   <= cfg_data[6:0];
                CFG_WRITE_WAIT_TICKS: wait_ticks_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    i2cem_engine #(
        .PAGE_BYTES   (PAGE_BYTES),
        .MEMORY_BYTES (MEMORY_BYTES)
    ) u_engine (
        .clk              (clk),
        .rst_n            (rst_n),
        .step_en          (advance),
        .cmd              (cmd_buf_reg),
        .device_address   (dev_addr_reg),
        .write_wait_ticks (wait_ticks_reg),
        .res              (step_res)
    );

    // Checks
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> cmd_full_reg)
        else $error("cmd stalled with empty input register");

    a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.done_res |-> res_data.status == ST_OK)
        else $error("status set without done");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.done_res |-> !res_data.busy_res)
        else $error("done while still busy");

    a_req_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_data.data_request && res_data.read_valid))
        else $error("data request and read byte in one tick");

endmodule

`default_nettype wire
